>>> rtl/gmm_pkg.sv
// gmm_pkg: shared types, register indexes and helper functions for the
// multichannel gap median monitor. No dependencies.
package gmm_pkg;

    localparam int unsigned MAX_CFG_CH = 4;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned OUT_DATA_W = 160;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESENT_MASK = 3'd0,
        CFG_TIMEOUT      = 3'd1,
        CFG_RATE_WINDOW  = 3'd2,
        CFG_OFFSET_CH0   = 3'd3,
        CFG_OFFSET_CH1   = 3'd4,
        CFG_OFFSET_CH2   = 3'd5,
        CFG_OFFSET_CH3   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [3:0]  range_status;
        logic [7:0]  range_mm;
        logic        sample_ready;
        logic        mux_ok;
        logic [31:0] now_ms;
    } t_item;

    typedef struct packed {
        logic               present;
        logic [15:0]        timeout_ms;
        logic signed [12:0] offset_q4;
    } t_lane_cfg;

    // per-channel state as it stands after the current step
    typedef struct packed {
        logic               fault;
        logic [31:0]        io_errors;
        logic [31:0]        status_errors;
        logic [31:0]        good_samples;
        logic [15:0]        window_rate;
        logic signed [13:0] median_gap;
        logic signed [13:0] gap;
        logic [3:0]         status;
        logic [7:0]         raw;
    } t_lane_view;

    typedef struct packed {
        logic [31:0]        io_error_count;
        logic [31:0]        status_error_count;
        logic [31:0]        sample_count;
        logic [15:0]        rate_per_window;
        logic [3:0]         fault_mask;
        logic signed [13:0] gap_median_q4;
        logic signed [13:0] gap_q4;
        logic [3:0]         sensor_status;
        logic [7:0]         raw_range;
        logic               new_sample;
        logic               channel_polled;
        logic [1:0]         polled_channel;
    } t_result;

    function automatic logic signed [13:0] gap_of(input logic [7:0] range_mm,
                                                  input logic signed [12:0] off);
        return $signed({2'b00, range_mm, 4'b0000}) - $signed({off[12], off});
    endfunction

    function automatic logic [7:0] mid3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        logic [7:0] lo;
        logic [7:0] hi;
        logic [7:0] m;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        m  = (hi < c) ? hi : c;
        return (lo > m) ? lo : m;
    endfunction

endpackage

>>> rtl/gmm_rr_select.sv
// gmm_rr_select: round-robin pointer and next-present-channel search.
// Depends on nothing but its parameter.
module gmm_rr_select #(
    parameter int unsigned CHANNELS = 4
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_adv,
    input  logic [CHANNELS-1:0]                     i_present,
    output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] o_sel,
    output logic                                    o_polled
);
    localparam int unsigned PTR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [PTR_W-1:0] LAST = PTR_W'(CHANNELS - 1);

    logic [PTR_W-1:0] r_ptr;
    logic [PTR_W-1:0] n_ptr;
    logic [PTR_W-1:0] sel;
    logic [PTR_W:0]   cand;
    logic             found;

    always_comb begin
        found = 1'b0;
        sel   = r_ptr;
        cand  = '0;
        for (int k = CHANNELS - 1; k >= 0; k--) begin
            cand = {1'b0, r_ptr} + (PTR_W+1)'(k);
            if (cand >= (PTR_W+1)'(CHANNELS)) begin
                cand = cand - (PTR_W+1)'(CHANNELS);
            end
            if (i_present[cand[PTR_W-1:0]]) begin
                found = 1'b1;
                sel   = cand[PTR_W-1:0];
            end
        end
    end

    always_comb begin
        n_ptr = r_ptr;
        if (i_adv && found) begin
            n_ptr = (sel == LAST) ? '0 : sel + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else begin
            r_ptr <= n_ptr;
        end
    end

    assign o_sel    = sel;
    assign o_polled = found;

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= LAST) else $error("round-robin pointer out of range");
    a_ptr_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && !found) |=> $stable(r_ptr))
        else $error("pointer moved with no channel present");

endmodule

>>> rtl/gmm_channel.sv
// gmm_channel: per-channel counters, stored sample, median history, timeout
// fault and window rate. Depends on gmm_pkg.
module gmm_channel (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic                  i_poll,
    input  logic                  i_latch,
    input  gmm_pkg::t_item        i_item,
    input  gmm_pkg::t_lane_cfg    i_cfg,
    output gmm_pkg::t_lane_view   o_view
);
    logic [7:0]         r_hist [3];
    logic [1:0]         r_fill;
    logic [31:0]        r_last_good;
    logic [31:0]        r_good;
    logic [31:0]        r_base;
    logic [15:0]        r_rate;
    logic [31:0]        r_serr;
    logic [31:0]        r_ioerr;
    logic [7:0]         r_raw;
    logic [3:0]         r_status;
    logic signed [13:0] r_gap;
    logic signed [13:0] r_median;

    logic [7:0]         n_hist [3];
    logic [1:0]         n_fill;
    logic [31:0]        n_last_good;
    logic [31:0]        n_good;
    logic [31:0]        n_base;
    logic [15:0]        n_rate;
    logic [31:0]        n_serr;
    logic [31:0]        n_ioerr;
    logic [7:0]         n_raw;
    logic [3:0]         n_status;
    logic signed [13:0] n_gap;
    logic signed [13:0] n_median;

    logic               poll;
    logic               take;
    logic               good;
    logic               bad;
    logic               io_fail;
    logic signed [13:0] new_gap;
    logic [31:0]        age;
    logic [31:0]        diff;

    assign poll    = i_fire && i_poll;
    assign io_fail = poll && !i_item.mux_ok;
    assign take    = poll && i_item.mux_ok && i_item.sample_ready;
    assign good    = take && (i_item.range_status == 4'd0);
    assign bad     = take && (i_item.range_status != 4'd0);
    assign new_gap = gmm_pkg::gap_of(i_item.range_mm, i_cfg.offset_q4);

    always_comb begin
        n_hist   = r_hist;
        n_fill   = r_fill;
        n_gap    = r_gap;
        n_median = r_median;
        if (good) begin
            n_gap = new_gap;
            if (r_fill != 2'd3) begin
                n_hist[r_fill] = i_item.range_mm;
                n_fill         = r_fill + 2'd1;
                n_median       = new_gap;
            end else begin
                n_hist[0] = r_hist[1];
                n_hist[1] = r_hist[2];
                n_hist[2] = i_item.range_mm;
                n_median  = gmm_pkg::gap_of(
                    gmm_pkg::mid3(r_hist[1], r_hist[2], i_item.range_mm), i_cfg.offset_q4);
            end
        end
    end

    assign n_ioerr     = r_ioerr + {31'd0, io_fail};
    assign n_serr      = r_serr + {31'd0, bad};
    assign n_good      = r_good + {31'd0, good};
    assign n_raw       = take ? i_item.range_mm : r_raw;
    assign n_status    = take ? i_item.range_status : r_status;
    assign n_last_good = good ? i_item.now_ms : r_last_good;
    assign diff        = n_good - r_base;
    assign n_rate      = (i_fire && i_latch) ? diff[15:0] : r_rate;
    assign n_base      = (i_fire && i_latch) ? n_good : r_base;
    assign age         = i_item.now_ms - r_last_good;

    always_ff @(posedge i_clk) begin
        r_hist <= n_hist;
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_last_good <= '0;
            r_good      <= '0;
            r_base      <= '0;
            r_rate      <= '0;
            r_serr      <= '0;
            r_ioerr     <= '0;
            r_raw       <= '0;
            r_status    <= '0;
            r_gap       <= '0;
            r_median    <= '0;
        end else begin
            r_fill      <= n_fill;
            r_last_good <= n_last_good;
            r_good      <= n_good;
            r_base      <= n_base;
            r_rate      <= n_rate;
            r_serr      <= n_serr;
            r_ioerr     <= n_ioerr;
            r_raw       <= n_raw;
            r_status    <= n_status;
            r_gap       <= n_gap;
            r_median    <= n_median;
        end
    end

    // a fresh good sample has age zero, so only the stored time is aged
    always_comb begin
        o_view.fault         = !i_cfg.present || (!good && (age > {16'd0, i_cfg.timeout_ms}));
        o_view.io_errors     = n_ioerr;
        o_view.status_errors = n_serr;
        o_view.good_samples  = n_good;
        o_view.window_rate   = n_rate;
        o_view.median_gap    = n_median;
        o_view.gap           = n_gap;
        o_view.status        = n_status;
        o_view.raw           = n_raw;
    end

endmodule

>>> rtl/multichannel_gap_median_monitor.sv
// multichannel_gap_median_monitor: top level; input register, config
// registers, rate window and result register. Depends on gmm_pkg,
// gmm_rr_select and gmm_channel.
//
//  port group   dir  width  contents
//  s_axis       in   48     poll outcome of one task tick
//  m_axis       out  160    status of the polled channel after the tick
//  i_cfg_*      in   3/16   register writes
//
// One item per cycle sustained while the output is not stalled; an item passes
// the input register, then the channel update into the result register. The
// per-channel update is a read-modify-write of lane registers.
// Synchronous active-low reset clears counters and pointer and returns config to its defaults.
// A stalled output holds the result; the input register still takes an item only while it is empty.
module multichannel_gap_median_monitor #(
    parameter int unsigned CHANNELS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // now_ms[31:0], mux_ok, sample_ready, range_mm[7:0], range_status[3:0], pad
    input  logic [gmm_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // polled_channel[1:0], channel_polled, new_sample, raw_range[7:0],
    // sensor_status[3:0], gap_q4[13:0], gap_median_q4[13:0], fault_mask[3:0],
    // rate_per_window[15:0], sample_count[31:0], status_error_count[31:0],
    // io_error_count[31:0]
    output logic [gmm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [gmm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [gmm_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);
    localparam int unsigned PTR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic               r_in_valid;
    gmm_pkg::t_item     r_item;
    logic               r_out_valid;
    gmm_pkg::t_result   r_out;
    gmm_pkg::t_result   n_out;
    logic [3:0]         r_mask;
    logic [15:0]        r_timeout;
    logic [15:0]        r_window;
    logic signed [12:0] r_offset [gmm_pkg::MAX_CFG_CH];
    logic [31:0]        r_win_start;

    logic                  fire;
    logic                  latch;
    logic [31:0]           win_age;
    logic [CHANNELS-1:0]   present;
    logic [CHANNELS-1:0]   fault;
    logic [PTR_W-1:0]      sel;
    logic [PTR_W+1:0]      sel_wide;
    logic                  polled;
    gmm_pkg::t_lane_cfg    lane_cfg  [CHANNELS];
    gmm_pkg::t_lane_view   lane_view [CHANNELS];
    gmm_pkg::t_lane_view   pick;
    logic [3:0]            fault4;

    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_item <= gmm_pkg::t_item'(s_axis_tdata[45:0]);
        end
        if (fire) begin
            r_out <= n_out;
        end
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_win_start <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (fire && latch) begin
                r_win_start <= r_item.now_ms;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask    <= '0;
            r_timeout <= 16'd100;
            r_window  <= 16'd1000;
            for (int i = 0; i < gmm_pkg::MAX_CFG_CH; i++) begin
                r_offset[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (gmm_pkg::t_cfg_idx'(i_cfg_idx))
                gmm_pkg::CFG_PRESENT_MASK: r_mask    <= i_cfg_wdata[3:0];
                gmm_pkg::CFG_TIMEOUT:      r_timeout <= i_cfg_wdata;
                gmm_pkg::CFG_RATE_WINDOW:  r_window  <= i_cfg_wdata;
                gmm_pkg::CFG_OFFSET_CH0:   r_offset[0] <= i_cfg_wdata[12:0];
                gmm_pkg::CFG_OFFSET_CH1:   r_offset[1] <= i_cfg_wdata[12:0];
                gmm_pkg::CFG_OFFSET_CH2:   r_offset[2] <= i_cfg_wdata[12:0];
                gmm_pkg::CFG_OFFSET_CH3:   r_offset[3] <= i_cfg_wdata[12:0];
                default: ;
            endcase
        end
    end

    assign win_age = r_item.now_ms - r_win_start;
    assign latch   = win_age >= {16'd0, r_window};

    gmm_rr_select #(.CHANNELS(CHANNELS)) u_rr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (fire),
        .i_present (present),
        .o_sel     (sel),
        .o_polled  (polled)
    );

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        if (c < gmm_pkg::MAX_CFG_CH) begin : g_cfg
            assign present[c]           = r_mask[c];
            assign lane_cfg[c].offset_q4 = r_offset[c];
        end else begin : g_none
            assign present[c]           = 1'b0;
            assign lane_cfg[c].offset_q4 = '0;
        end
        assign lane_cfg[c].present    = present[c];
        assign lane_cfg[c].timeout_ms = r_timeout;
        assign fault[c]               = lane_view[c].fault;

        gmm_channel u_ch (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_fire  (fire),
            .i_poll  (polled && (sel == PTR_W'(c))),
            .i_latch (latch),
            .i_item  (r_item),
            .i_cfg   (lane_cfg[c]),
            .o_view  (lane_view[c])
        );
    end

    for (genvar b = 0; b < 4; b++) begin : g_fault
        if (b < CHANNELS) begin : g_on
            assign fault4[b] = fault[b];
        end else begin : g_off
            assign fault4[b] = 1'b0;
        end
    end

    assign pick     = lane_view[sel];
    assign sel_wide = (PTR_W+2)'(sel);

    always_comb begin
        n_out.polled_channel     = sel_wide[1:0];
        n_out.channel_polled     = polled;
        n_out.new_sample         = polled && r_item.mux_ok && r_item.sample_ready &&
                                   (r_item.range_status == 4'd0);
        n_out.raw_range          = pick.raw;
        n_out.sensor_status      = pick.status;
        n_out.gap_q4             = pick.gap;
        n_out.gap_median_q4      = pick.median_gap;
        n_out.fault_mask         = fault4;
        n_out.rate_per_window    = pick.window_rate;
        n_out.sample_count       = pick.good_samples;
        n_out.status_error_count = pick.status_errors;
        n_out.io_error_count     = pick.io_errors;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    a_new_needs_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.new_sample) |-> r_out.channel_polled)
        else $error("new sample without a polled channel");
    a_new_not_faulted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.new_sample) |-> !r_out.fault_mask[r_out.polled_channel])
        else $error("fresh channel flagged as faulted");
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> s_axis_tready)
        else $error("input stalled with empty input register");

endmodule
